// ===== hw/rtl/iopm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the I/O port permission map.
package iopm_pkg;

	localparam int unsigned ROW_BITS  = 32;
	localparam int unsigned ROW_IDX_W = 5;
	localparam int unsigned COUNT_W   = 18;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [1:0]         RIGHTS_ALL = 2'b11;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2
	} mode_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EXISTS = 2'd1,
		ST_NOMEM  = 2'd2,
		ST_BAD    = 2'd3
	} status_e;

	typedef struct packed {
		mode_e       mode;
		logic [15:0] port;
		logic        all_ports;
		logic        page_available;
	} req_t;

	typedef struct packed {
		status_e            status;
		logic               mapped;
		logic [1:0]         rights;
		logic               size_whole;
		logic [15:0]        base_port;
		logic [COUNT_W-1:0] port_count;
	} rsp_t;

endpackage

// ===== hw/rtl/io_port_permission_map_core.sv =====
`timescale 1ns / 1ps
// Top level of the I/O port permission map: request sequencer and bitmap state.
//
// Keeps one deny bit per I/O port (1 = disabled) in a RAM of 32-bit rows, plus a
// present flag per half of the port space, a granted-port counter and a
// whole-space grant flag. Each transaction is a lookup, insert or delete: raise
// start with the request while busy is low. In each transaction the accepting
// edge launches the read of the port's bitmap row from the registered-read RAM,
// the row lands in the next cycle, which updates the row and the flags and writes
// the row back at its closing edge, and the result is then shown on result for
// exactly one cycle with done high. The receiver cannot stall results; take them
// when done is high. A new request is accepted in the same cycle a result is
// presented. After reset the block sweeps the bitmap RAM to all ones, one row
// per cycle, over ceil(PORTS/32) rows (2048 at PORTS = 65536); busy stays high
// during this sweep. A half of the port space that is not yet present always
// holds all ones, so making it present needs no refill.
module io_port_permission_map_core
	import iopm_pkg::*;
#(
	parameter int unsigned PORTS = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int unsigned HALF_PORTS = PORTS / 2;
	localparam int unsigned ROWS       = (PORTS + ROW_BITS - 1) / ROW_BITS;
	localparam int unsigned AW         = $clog2(ROWS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_row_q;
	req_t               req_q;
	logic [1:0]         half_present_q;
	logic [COUNT_W-1:0] count_q;
	logic               whole_q;
	logic               done_q;
	rsp_t               rsp_q;

	// Bitmap RAM ports
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ROW_BITS-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [ROW_BITS-1:0] ram_rdata;

	// Next-state values computed during execution
	rsp_t               rsp_d;
	logic [COUNT_W-1:0] count_d;
	logic               whole_d;
	logic [1:0]         half_present_d;
	logic               wr_bit_en;
	logic               wr_bit_val;

	logic                 in_range;
	logic                 half_sel;
	logic                 deny;
	logic                 granted;
	logic [ROW_IDX_W-1:0] bit_idx;
	logic [15:0]          in_row_full;
	logic [15:0]          q_row_full;
	logic [ROW_BITS-1:0]  row_mod;

	iopm_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Row address of the incoming request; the read lands in the execute cycle.
	assign in_row_full = request.port >> ROW_IDX_W;
	assign ram_raddr   = in_row_full[AW-1:0];

	assign q_row_full = req_q.port >> ROW_IDX_W;
	assign bit_idx    = req_q.port[ROW_IDX_W-1:0];

	assign in_range = 32'(req_q.port) < PORTS;
	assign half_sel = (32'(req_q.port) >= HALF_PORTS) && (32'(req_q.port) < 2 * HALF_PORTS);
	assign deny     = ram_rdata[bit_idx];
	assign granted  = in_range && half_present_q[half_sel] && !deny;

	// Decode the held request against the row just read.
	always_comb begin
		rsp_d          = '0;
		rsp_d.status   = ST_OK;
		count_d        = count_q;
		whole_d        = whole_q;
		half_present_d = half_present_q;
		wr_bit_en      = 1'b0;
		wr_bit_val     = 1'b0;
		unique case (req_q.mode)
			MODE_LOOKUP: begin
				if (whole_q) begin
					rsp_d.mapped     = 1'b1;
					rsp_d.rights     = RIGHTS_ALL;
					rsp_d.size_whole = 1'b1;
				end else if (granted) begin
					rsp_d.mapped    = 1'b1;
					rsp_d.rights    = RIGHTS_ALL;
					rsp_d.base_port = req_q.port;
				end else if (count_q == '0) begin
					rsp_d.size_whole = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (req_q.all_ports) begin
					if (count_q == '0) begin
						whole_d = 1'b1;
						count_d = COUNT_W'(PORTS);
					end else begin
						rsp_d.status = ST_BAD;
					end
				end else if (!in_range) begin
					rsp_d.status = ST_BAD;
				end else if (!half_present_q[half_sel] && !req_q.page_available) begin
					rsp_d.status = ST_NOMEM;
				end else begin
					// An absent half already reads as all ones: just mark it present.
					half_present_d[half_sel] = 1'b1;
					if (deny) begin
						wr_bit_en  = 1'b1;
						wr_bit_val = 1'b0;
						if (count_q != COUNT_MAX) begin
							count_d = count_q + 1'b1;
						end
					end else begin
						rsp_d.status = ST_EXISTS;
					end
				end
			end
			MODE_DELETE: begin
				if (whole_q) begin
					whole_d      = 1'b0;
					count_d      = '0;
					rsp_d.rights = RIGHTS_ALL;
				end else if (!in_range) begin
					rsp_d.status = ST_BAD;
				end else if (granted) begin
					wr_bit_en    = 1'b1;
					wr_bit_val   = 1'b1;
					rsp_d.rights = RIGHTS_ALL;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				rsp_d.status = ST_BAD;
			end
		endcase
		rsp_d.port_count = count_d;
	end

	// Patch one bit of the row read back for the write-back.
	always_comb begin
		row_mod          = ram_rdata;
		row_mod[bit_idx] = wr_bit_val;
	end

	// Write port: all-ones sweep after reset, otherwise the modified row.
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_row_q;
			ram_wdata = '1;
		end else begin
			ram_we    = (state_q == S_EXEC) && wr_bit_en;
			ram_waddr = q_row_full[AW-1:0];
			ram_wdata = row_mod;
		end
	end

	// Sequencer: clear sweep, accept, execute and present the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_row_q      <= '0;
			half_present_q <= '0;
			count_q        <= '0;
			whole_q        <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == AW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					half_present_q <= half_present_d;
					count_q        <= count_d;
					whole_q        <= whole_d;
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: hold the request and the result.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= request;
		end
		if (state_q == S_EXEC) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

// ===== hw/rtl/iopm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module iopm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/iopm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the I/O port permission map, bound to the top level.
module iopm_checker
	import iopm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input rsp_t result
);

	// An accepted transaction completes with done raised after its execute state.
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result missing two cycles after accept");

	// A result only follows a busy execute cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	// The block is ready again while it presents a result.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while presenting a result");

	// Lookup-only fields stay zero for any failed transaction.
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |->
			!result.mapped && !result.size_whole && result.base_port == '0)
		else $error("lookup fields set on a failed transaction");

endmodule

bind io_port_permission_map_core iopm_checker u_iopm_checker (.*);

// ===== tb/io_port_permission_map_core_checker.sv =====
`timescale 1ns / 1ps
// Transaction monitor for the I/O port permission map: predicts every reply and compares it.
module io_port_permission_map_core_checker
	import iopm_pkg::*;
#(
	parameter int unsigned PORTS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        request,
	input  logic        done,
	input  rsp_t        result,
	output int unsigned fail_count,
	output int unsigned replies_seen,
	output int unsigned outstanding
);

	localparam int unsigned HALF_PORTS = PORTS / 2;

	// shadow copy of the permission state
	bit [PORTS-1:0]   deny_map;
	bit [1:0]         half_live;
	bit [COUNT_W-1:0] granted;
	bit               whole_flag;

	rsp_t replies_due[$];

	function automatic bit port_open(int unsigned p);
		if (p >= PORTS)
			return 1'b0;
		if (!half_live[p / HALF_PORTS])
			return 1'b0;
		return !deny_map[p];
	endfunction

	// update the shadow state for one transaction and return the reply it earns
	function automatic rsp_t resolve_request(req_t r);
		rsp_t        rsp;
		int unsigned p;
		int unsigned half;
		rsp = '0;
		rsp.status = ST_OK;
		p = r.port;
		half = (p / HALF_PORTS) & 1;
		case (r.mode)
			MODE_LOOKUP: begin
				if (whole_flag) begin
					rsp.mapped = 1'b1;
					rsp.rights = RIGHTS_ALL;
					rsp.size_whole = 1'b1;
				end else if (port_open(p)) begin
					rsp.mapped = 1'b1;
					rsp.rights = RIGHTS_ALL;
					rsp.base_port = r.port;
				end else if (granted == 0) begin
					rsp.size_whole = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (r.all_ports) begin
					if (granted == 0) begin
						whole_flag = 1'b1;
						granted = COUNT_W'(PORTS);
					end else begin
						rsp.status = ST_BAD;
					end
				end else if (p >= PORTS) begin
					rsp.status = ST_BAD;
				end else if (!half_live[half] && !r.page_available) begin
					rsp.status = ST_NOMEM;
				end else begin
					if (!half_live[half]) begin
						deny_map[half * HALF_PORTS +: HALF_PORTS] = '1;
						half_live[half] = 1'b1;
					end
					if (deny_map[p]) begin
						deny_map[p] = 1'b0;
						if (granted != COUNT_MAX)
							granted++;
					end else begin
						rsp.status = ST_EXISTS;
					end
				end
			end
			MODE_DELETE: begin
				if (whole_flag) begin
					whole_flag = 1'b0;
					granted = '0;
					rsp.rights = RIGHTS_ALL;
				end else if (p >= PORTS) begin
					rsp.status = ST_BAD;
				end else if (port_open(p)) begin
					deny_map[p] = 1'b1;
					if (granted != 0)
						granted--;
					rsp.rights = RIGHTS_ALL;
				end
			end
			default: begin
				rsp.status = ST_BAD;
			end
		endcase
		rsp.port_count = granted;
		return rsp;
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			deny_map = '1;
			half_live = '0;
			granted = '0;
			whole_flag = 1'b0;
			replies_due.delete();
			fail_count = 0;
			replies_seen = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("reply with no transaction pending");
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, result.status);
					check_field("mapped", want.mapped, result.mapped);
					check_field("rights", want.rights, result.rights);
					check_field("size_whole", want.size_whole, result.size_whole);
					check_field("base_port", want.base_port, result.base_port);
					check_field("port_count", want.port_count, result.port_count);
				end
				replies_seen++;
			end
			if (start && !busy)
				replies_due.push_back(resolve_request(request));
			outstanding = replies_due.size();
		end
	end

endmodule

// ===== tb/io_port_permission_map_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the I/O port permission map: stimulus, timeout and verdict.
module io_port_permission_map_core_tb;
	import iopm_pkg::*;

	localparam int unsigned PORTS        = 65536;
	localparam int unsigned TOTAL_ITEMS  = 1525;    // directed part plus about 1500 random
	localparam int unsigned POOL_SIZE    = 16;
	localparam int unsigned DRAIN_CYCLES = 8;
	// reset sweep plus every transaction and the longest gap,
	// taken several times over
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// the mode encoding that the block must reject
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	int unsigned fail_count;
	int unsigned replies_seen;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned sent_items = 0;

	// a small set of ports that most random traffic hits, so that inserts,
	// lookups and deletes keep landing on the same bitmap bits
	logic [15:0] port_pool[POOL_SIZE];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	io_port_permission_map_core #(
		.PORTS(PORTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	io_port_permission_map_core_checker #(
		.PORTS(PORTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.fail_count(fail_count),
		.replies_seen(replies_seen),
		.outstanding(outstanding)
	);

	function automatic req_t make_req(logic [1:0] m, logic [15:0] p, logic w, logic pg);
		req_t r;
		r.mode = mode_e'(m);
		r.port = p;
		r.all_ports = w;
		r.page_available = pg;
		return r;
	endfunction

	// mostly well-formed traffic on the pool, with a few reserved modes mixed in
	function automatic req_t pool_req();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.port = port_pool[$urandom_range(POOL_SIZE - 1)];
		r.all_ports = ($urandom_range(9) == 0);
		r.page_available = ($urandom_range(4) != 0);
		if (pick < 30)
			r.mode = MODE_LOOKUP;
		else if (pick < 65)
			r.mode = MODE_INSERT;
		else if (pick < 95)
			r.mode = MODE_DELETE;
		else
			r.mode = mode_e'(MODE_RESERVED);
		return r;
	endfunction

	// present one transaction and hold it until the block takes it
	task automatic send(req_t r);
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_items++;
	endtask

	// drop start for a random number of cycles; zero keeps the burst going
	task automatic idle_gap(int unsigned max_gap);
		int unsigned gap;
		gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(max_gap, 1);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : timeout
		wait (cycle_count >= CYCLE_LIMIT);
		$display("io_port_permission_map_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		req_t        directed[$];
		logic [15:0] p;
		int unsigned pick;
		int unsigned burst;

		// hold reset, then release it once for good
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the corner cases: empty map, absent halves with and without a page,
		// half boundaries, repeat inserts, whole-space grant and its interaction
		// with single ports, counter floor at zero and the reserved mode
		directed = '{
			make_req(MODE_LOOKUP, 16'h0000, 1'b0, 1'b0),
			make_req(MODE_DELETE, 16'h4000, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'h0000, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'hFFFF, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'h7FFF, 1'b0, 1'b1),
			make_req(MODE_INSERT, 16'h7FFF, 1'b0, 1'b1),
			make_req(MODE_INSERT, 16'h8000, 1'b0, 1'b1),
			make_req(MODE_INSERT, 16'hFFFF, 1'b0, 1'b0),
			make_req(MODE_LOOKUP, 16'h8000, 1'b1, 1'b1),
			make_req(MODE_LOOKUP, 16'h1234, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'h0000, 1'b1, 1'b1),
			make_req(MODE_DELETE, 16'h7FFF, 1'b1, 1'b1),
			make_req(MODE_DELETE, 16'h7FFF, 1'b0, 1'b0),
			make_req(MODE_DELETE, 16'h8000, 1'b0, 1'b0),
			make_req(MODE_DELETE, 16'hFFFF, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'hFFFF, 1'b1, 1'b0),
			make_req(MODE_LOOKUP, 16'hABCD, 1'b0, 1'b0),
			make_req(MODE_INSERT, 16'h0000, 1'b0, 1'b1),
			make_req(MODE_DELETE, 16'h5555, 1'b0, 1'b0),
			make_req(MODE_LOOKUP, 16'h0000, 1'b0, 1'b0),
			make_req(MODE_DELETE, 16'h0000, 1'b0, 1'b0),
			make_req(MODE_RESERVED, 16'hFFFF, 1'b1, 1'b1),
			make_req(MODE_INSERT, 16'h0000, 1'b1, 1'b1),
			make_req(MODE_DELETE, 16'hFFFF, 1'b1, 1'b0)
		};
		foreach (directed[i]) begin
			send(directed[i]);
			idle_gap(2);
		end

		foreach (port_pool[i])
			port_pool[i] = 16'($urandom);

		while (sent_items < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				// random operations on the pool, in bursts of varying length
				burst = $urandom_range(40, 1);
				repeat (burst) begin
					send(pool_req());
					if ($urandom_range(3) == 0)
						idle_gap(3);
				end
			end else if (pick < 90) begin
				// drain the pool so the counter reaches zero, claim the whole
				// space, add a port on top of it, then end the grant
				foreach (port_pool[i])
					send(make_req(MODE_DELETE, port_pool[i], 1'($urandom), 1'($urandom)));
				send(make_req(MODE_INSERT, 16'($urandom), 1'b1, 1'($urandom)));
				send(make_req(MODE_LOOKUP, 16'($urandom), 1'($urandom), 1'($urandom)));
				send(make_req(MODE_INSERT, port_pool[$urandom_range(POOL_SIZE - 1)],
					1'b0, 1'b1));
				send(make_req(MODE_DELETE, 16'($urandom), 1'($urandom), 1'($urandom)));
				send(make_req(MODE_LOOKUP, port_pool[$urandom_range(POOL_SIZE - 1)],
					1'b0, 1'b0));
			end else begin
				// noise: any port anywhere; a delete follows each insert, which clears it unless a whole grant is on
				p = 16'($urandom);
				case ($urandom_range(2))
					0: send(make_req(MODE_LOOKUP, p, 1'($urandom), 1'($urandom)));
					1: begin
						send(make_req(MODE_INSERT, p, 1'b0, 1'($urandom)));
						send(make_req(MODE_DELETE, p, 1'($urandom), 1'($urandom)));
					end
					default: send(make_req(MODE_RESERVED, p, 1'($urandom), 1'($urandom)));
				endcase
			end
			idle_gap(7);
		end
		start <= 1'b0;

		// wait for every reply, then let the pipeline settle
		wait (replies_seen >= sent_items);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("io_port_permission_map_core regression: pass");
		else
			$display("io_port_permission_map_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/iopm_pkg.sv
hw/rtl/iopm_ram.sv
hw/rtl/io_port_permission_map_core.sv
hw/rtl/iopm_checker.sv
tb/io_port_permission_map_core_checker.sv
tb/io_port_permission_map_core_tb.sv
